// File: src/tss_pkg.sv
package tss_pkg;

    // Storage geometry
    localparam int DEPTH      = 256;
    localparam int DATA_WIDTH = 32;
    localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FILL_W     = $clog2(DEPTH + 1);

    // Port field widths
    localparam int VALUE_W  = 32;
    localparam int COUNT_W  = 9;
    localparam int STATUS_W = 2;

    typedef enum logic [1:0] {
        ACT_PUSH_ONE = 2'd0,
        ACT_PUSH_TWO = 2'd1,
        ACT_POP_ONE  = 2'd2,
        ACT_POP_TWO  = 2'd3
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_OVERFLOW  = 2'd1,
        STAT_UNDERFLOW = 2'd2
    } t_status;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic load_out;
    } t_cmd;

endpackage

// File: src/two_stacks_shared_memory.sv
// Two stacks in one shared single-port memory, one push or pop per beat.
// The memory is accessed at the accepting edge; the output registers load
// from the EXEC state once the output register is free.
// The input takes no new beat until the last has loaded its result from
// the registered read and stalls further while a result waits on i_stall.
// Reset: synchronous, active low; both stacks empty, output invalid.
// Memory contents are not cleared.
module two_stacks_shared_memory (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  tss_pkg::t_action                i_action,
    input  logic [tss_pkg::VALUE_W-1:0]     i_push_value,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [tss_pkg::VALUE_W-1:0]     o_pop_value,
    output logic [tss_pkg::STATUS_W-1:0]    o_status,
    output logic [tss_pkg::COUNT_W-1:0]     o_count_one,
    output logic [tss_pkg::COUNT_W-1:0]     o_count_two
);
    import tss_pkg::*;

    t_cmd cmd;

    tss_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_cmd   (cmd)
    );

    tss_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_action     (i_action),
        .i_push_value (i_push_value),
        .o_pop_value  (o_pop_value),
        .o_status     (o_status),
        .o_count_one  (o_count_one),
        .o_count_two  (o_count_two)
    );

endmodule

// File: src/tss_ctrl.sv
module tss_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    output logic          o_valid,
    input  logic          i_stall,
    output tss_pkg::t_cmd o_cmd
);
    import tss_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || !i_stall;

    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_EXEC;
                end
            end
            ST_EXEC: begin
                // hold the result until the output register frees up
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_stall = (r_state != ST_IDLE);
    assign o_valid = r_out_valid;

endmodule

// File: src/tss_dp.sv
module tss_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  tss_pkg::t_cmd                   i_cmd,
    input  tss_pkg::t_action                i_action,
    input  logic [tss_pkg::VALUE_W-1:0]     i_push_value,
    output logic [tss_pkg::VALUE_W-1:0]     o_pop_value,
    output logic [tss_pkg::STATUS_W-1:0]    o_status,
    output logic [tss_pkg::COUNT_W-1:0]     o_count_one,
    output logic [tss_pkg::COUNT_W-1:0]     o_count_two
);
    import tss_pkg::*;

    logic [DATA_WIDTH-1:0] mem [DEPTH];

    logic [FILL_W-1:0]     r_fill_one, n_fill_one;
    logic [FILL_W-1:0]     r_fill_two, n_fill_two;
    logic [DATA_WIDTH-1:0] r_rd_data;
    logic                  r_pop_ok;
    t_status               r_status, n_status;

    logic [VALUE_W-1:0]    r_out_value;
    logic [STATUS_W-1:0]   r_out_status;
    logic [COUNT_W-1:0]    r_out_one;
    logic [COUNT_W-1:0]    r_out_two;

    logic [FILL_W:0]       fill_sum;
    logic                  full;
    logic [FILL_W-1:0]     addr_wide;
    logic [ADDR_W-1:0]     addr;
    logic                  do_write;
    logic                  do_read;

    assign fill_sum = {1'b0, r_fill_one} + {1'b0, r_fill_two};
    assign full     = (fill_sum >= (FILL_W+1)'(DEPTH));

    always_comb begin
        n_fill_one = r_fill_one;
        n_fill_two = r_fill_two;
        n_status   = STAT_OK;
        addr_wide  = '0;
        do_write   = 1'b0;
        do_read    = 1'b0;
        unique case (i_action)
            ACT_PUSH_ONE: begin
                addr_wide = r_fill_one;
                if (full) begin
                    n_status = STAT_OVERFLOW;
                end else begin
                    do_write   = 1'b1;
                    n_fill_one = r_fill_one + 1'b1;
                end
            end
            ACT_PUSH_TWO: begin
                addr_wide = FILL_W'(DEPTH - 1) - r_fill_two;
                if (full) begin
                    n_status = STAT_OVERFLOW;
                end else begin
                    do_write   = 1'b1;
                    n_fill_two = r_fill_two + 1'b1;
                end
            end
            ACT_POP_ONE: begin
                addr_wide = r_fill_one - 1'b1;
                if (r_fill_one == '0) begin
                    n_status = STAT_UNDERFLOW;
                end else begin
                    do_read    = 1'b1;
                    n_fill_one = r_fill_one - 1'b1;
                end
            end
            ACT_POP_TWO: begin
                addr_wide = FILL_W'(DEPTH) - r_fill_two;
                if (r_fill_two == '0) begin
                    n_status = STAT_UNDERFLOW;
                end else begin
                    do_read    = 1'b1;
                    n_fill_two = r_fill_two - 1'b1;
                end
            end
            default: n_status = STAT_OK;
        endcase
    end

    assign addr = addr_wide[ADDR_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture && do_write) begin
            mem[addr] <= DATA_WIDTH'(i_push_value);
        end
        if (i_cmd.capture && do_read) begin
            r_rd_data <= mem[addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill_one <= '0;
            r_fill_two <= '0;
        end else if (i_cmd.capture) begin
            r_fill_one <= n_fill_one;
            r_fill_two <= n_fill_two;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_status <= n_status;
            r_pop_ok <= do_read;
        end
        if (i_cmd.load_out) begin
            r_out_value  <= r_pop_ok ? VALUE_W'(r_rd_data) : '0;
            r_out_status <= r_status;
            r_out_one    <= COUNT_W'(r_fill_one);
            r_out_two    <= COUNT_W'(r_fill_two);
        end
    end

    assign o_pop_value = r_out_value;
    assign o_status    = r_out_status;
    assign o_count_one = r_out_one;
    assign o_count_two = r_out_two;

endmodule
